/* design/tds_pkg.sv */
// Package for the task dispatch sweep block: sizes, codes and transaction types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package tds_pkg;

    localparam int WORKERS      = 8;
    localparam int QUEUE_DEPTH  = 16;
    localparam int WIDX_W       = $clog2(WORKERS);
    localparam int WCNT_W       = $clog2(WORKERS + 1);
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W         = 16;
    localparam int UNITS_W      = 16;
    localparam int PROG_W       = 17;
    localparam int MASK_W       = 8;

    localparam logic [PROG_W-1:0] PROGRESS_STEP = PROG_W'(2);

    typedef enum logic [2:0] {
        EV_DISPATCHED = 3'd0,
        EV_COMPLETED  = 3'd1,
        EV_BUSY       = 3'd2,
        EV_OFFLINE    = 3'd3,
        EV_IDLE       = 3'd4,
        EV_ENQUEUED   = 3'd5,
        EV_FULL       = 3'd6
    } t_event;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ENQ,
        S_SWEEP
    } t_state;

    typedef struct packed {
        logic               action;
        logic [ID_W-1:0]    task_id;
        logic [UNITS_W-1:0] work_units;
    } t_in_item;

    typedef struct packed {
        logic [2:0]        worker;
        logic [2:0]        event_res;
        logic [ID_W-1:0]   event_task_id;
        logic [PROG_W-1:0] progress;
        logic [4:0]        queue_count;
        logic              last;
    } t_out_item;

    typedef struct packed {
        logic [UNITS_W-1:0] work;
        logic [ID_W-1:0]    id;
    } t_task_entry;

    typedef struct packed {
        logic [QCNT_W-1:0] fill;
        t_task_entry       head;
    } t_fifo_stat;

    typedef struct packed {
        t_event            ev;
        logic [ID_W-1:0]   task_id;
        logic [PROG_W-1:0] progress;
        logic              pop;
    } t_step_res;

endpackage

/* design/tds_fifo.sv */
// Pending task queue: circular buffer memory with head, tail and fill count.
// Depends on tds_pkg.
`timescale 1ns / 1ps

module tds_fifo
    import tds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_task_entry i_push_data,
    input  logic        i_pop,
    output t_fifo_stat  o_stat
);

    t_task_entry       r_mem [QUEUE_DEPTH];
    t_task_entry       r_rd_data;
    logic [QPTR_W-1:0] r_head, n_head;
    logic [QPTR_W-1:0] r_tail, n_tail;
    logic [QCNT_W-1:0] r_fill, n_fill;

    function automatic logic [QPTR_W-1:0] wrap_next(input logic [QPTR_W-1:0] idx);
        logic [QPTR_W-1:0] res;
        if (idx == QPTR_W'(QUEUE_DEPTH - 1)) begin
            res = '0;
        end else begin
            res = idx + QPTR_W'(1);
        end
        return res;
    endfunction

    always_comb begin
        n_head = i_pop ? wrap_next(r_head) : r_head;
        n_tail = i_push ? wrap_next(r_tail) : r_tail;
        n_fill = r_fill;
        if (i_push && !i_pop) begin
            n_fill = r_fill + QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_fill = r_fill - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
            r_fill <= '0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_push_data;
        end
        r_rd_data <= r_mem[n_head];
    end

    assign o_stat.fill = r_fill;
    assign o_stat.head = r_rd_data;

endmodule

/* design/tds_workers.sv */
// Worker slot state; the shared step unit updates one worker per stepped cycle.
// Depends on tds_pkg.
`timescale 1ns / 1ps

module tds_workers
    import tds_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [WIDX_W-1:0]  i_idx,
    input  logic               i_offline,
    input  t_fifo_stat         i_fifo,
    output t_step_res          o_res,
    output logic [WORKERS-1:0] o_busy
);

    logic [WORKERS-1:0] r_busy;
    logic [ID_W-1:0]    r_task [WORKERS];
    logic [UNITS_W-1:0] r_work [WORKERS];
    logic [PROG_W-1:0]  r_prog [WORKERS];

    logic               cur_busy;
    logic [PROG_W-1:0]  p_next;
    logic               done;

    always_comb begin
        cur_busy = r_busy[i_idx];
        p_next   = r_prog[i_idx] + PROGRESS_STEP;
        done     = p_next >= {1'b0, r_work[i_idx]};
        o_res    = '{ev: EV_IDLE, task_id: '0, progress: '0, pop: 1'b0};
        if (i_offline) begin
            o_res.ev = EV_OFFLINE;
            if (cur_busy) begin
                o_res.task_id  = r_task[i_idx];
                o_res.progress = r_prog[i_idx];
            end
        end else if (!cur_busy) begin
            if (i_fifo.fill != '0) begin
                o_res.ev      = EV_DISPATCHED;
                o_res.task_id = i_fifo.head.id;
                o_res.pop     = i_step;
            end
        end else begin
            o_res.ev       = done ? EV_COMPLETED : EV_BUSY;
            o_res.task_id  = r_task[i_idx];
            o_res.progress = p_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= '0;
        end else if (i_step && !i_offline) begin
            if (!cur_busy) begin
                if (i_fifo.fill != '0) begin
                    r_busy[i_idx] <= 1'b1;
                end
            end else if (done) begin
                r_busy[i_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && !i_offline) begin
            if (!cur_busy) begin
                if (i_fifo.fill != '0) begin
                    r_task[i_idx] <= i_fifo.head.id;
                    r_work[i_idx] <= i_fifo.head.work;
                    r_prog[i_idx] <= '0;
                end
            end else begin
                r_prog[i_idx] <= p_next;
            end
        end
    end

    assign o_busy = r_busy;

endmodule

/* design/task_dispatch_sweep_top.sv */
// Top level of the task dispatch sweep block: sequencer, output register, config.
// Depends on tds_pkg, tds_fifo and tds_workers.
`timescale 1ns / 1ps

// An enqueue transaction gives one result. A sweep transaction gives eight results,
// one per worker in index order, because a single step unit updates one worker slot
// per cycle while the output is not stalled; the input is stalled until the last
// result has entered the output register. An output stall holds the sequencer in its
// state. Every result of a sweep carries the queue count after the whole sweep. The
// offline mask is written through the configuration channel, which is always ready.
module task_dispatch_sweep_top
    import tds_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MASK_W-1:0] i_cfg_data
);

    localparam logic [WIDX_W-1:0] LAST_IDX = WIDX_W'(WORKERS - 1);

    t_state            r_state, n_state;
    logic [WIDX_W-1:0] r_idx;
    logic [ID_W-1:0]   r_task_id;
    logic [UNITS_W-1:0] r_work_units;
    logic [QCNT_W-1:0] r_sweep_fill;
    logic [MASK_W-1:0] r_mask;
    logic              r_out_valid;
    t_out_item         r_out_data;

    logic              in_accept;
    logic              out_free;
    logic              push_en;
    t_task_entry       push_data;
    logic              step_en;
    logic              emit;
    t_out_item         emit_data;
    t_fifo_stat        fifo_stat;
    t_step_res         step_res;
    logic [WORKERS-1:0] busy_vec;
    logic [WCNT_W-1:0] avail;
    logic [QCNT_W-1:0] avail_ext;
    logic [QCNT_W-1:0] take;
    logic              is_full;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign is_full     = (fifo_stat.fill == QCNT_W'(QUEUE_DEPTH));
    assign push_data.work = r_work_units;
    assign push_data.id   = r_task_id;

    always_comb begin
        avail = '0;
        for (int i = 0; i < WORKERS; i++) begin
            avail = avail + WCNT_W'(!busy_vec[i] && !r_mask[i]);
        end
        avail_ext = QCNT_W'(avail);
        take      = (avail_ext < fifo_stat.fill) ? avail_ext : fifo_stat.fill;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = i_in_data.action ? S_SWEEP : S_ENQ;
                end
            end
            S_ENQ: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SWEEP: begin
                if (out_free && r_idx == LAST_IDX) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        push_en   = 1'b0;
        step_en   = 1'b0;
        emit      = 1'b0;
        emit_data = '0;
        case (r_state)
            S_ENQ: begin
                emit                    = out_free;
                push_en                 = out_free && !is_full;
                emit_data.event_task_id = r_task_id;
                emit_data.last          = 1'b1;
                if (is_full) begin
                    emit_data.event_res   = EV_FULL;
                    emit_data.queue_count = fifo_stat.fill;
                end else begin
                    emit_data.event_res   = EV_ENQUEUED;
                    emit_data.queue_count = fifo_stat.fill + QCNT_W'(1);
                end
            end
            S_SWEEP: begin
                emit                    = out_free;
                step_en                 = out_free;
                emit_data.worker        = 3'(r_idx);
                emit_data.event_res     = step_res.ev;
                emit_data.event_task_id = step_res.task_id;
                emit_data.progress      = step_res.progress;
                emit_data.queue_count   = r_sweep_fill;
                emit_data.last          = (r_idx == LAST_IDX);
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_accept) begin
                r_idx <= '0;
            end else if (step_en) begin
                r_idx <= r_idx + WIDX_W'(1);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_mask <= i_cfg_data;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_task_id    <= i_in_data.task_id;
            r_work_units <= i_in_data.work_units;
            r_sweep_fill <= fifo_stat.fill - take;
        end
        if (emit) begin
            r_out_data <= emit_data;
        end
    end

    tds_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push_en),
        .i_push_data (push_data),
        .i_pop       (step_res.pop),
        .o_stat      (fifo_stat)
    );

    tds_workers u_workers (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step_en),
        .i_idx     (r_idx),
        .i_offline (r_mask[r_idx]),
        .i_fifo    (fifo_stat),
        .o_res     (step_res),
        .o_busy    (busy_vec)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fifo_stat.fill <= QCNT_W'(QUEUE_DEPTH))
        else $error("Queue fill count exceeds the queue depth.");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step_res.pop |-> fifo_stat.fill != '0)
        else $error("Dispatch from an empty queue.");

    a_sweep_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP && step_en && r_idx == LAST_IDX)
        |=> fifo_stat.fill == $past(r_sweep_fill))
        else $error("Queue count after a sweep differs from the reported count.");

    a_push_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push_en |=> fifo_stat.fill == $past(fifo_stat.fill) + QCNT_W'(1))
        else $error("Enqueue did not advance the queue count.");

endmodule

/* sim/task_dispatch_sweep_top_tb.sv */
// Self-checking testbench for task_dispatch_sweep_top: random and directed enqueue and
// sweep transactions against a dispatch predictor kept in a small scoreboard class.
// Depends on tds_pkg and task_dispatch_sweep_top.
`timescale 1ns / 1ps

module task_dispatch_sweep_top_tb;
    import tds_pkg::*;

    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_SWEEP   = 1'b1;

    localparam int PHASES        = 7;
    localparam int PHASE_ITEMS   = 50;
    localparam int BURST_ITEMS   = 12;
    localparam int LONG_HOLD     = 80;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 20;

    localparam logic [MASK_W-1:0] PHASE_MASKS [PHASES] =
        '{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h00, 8'h0F, 8'h00};

    class dispatch_board;
        t_task_entry       pending_q [QUEUE_DEPTH];
        logic [QPTR_W-1:0] head_ptr = '0;
        logic [QPTR_W-1:0] tail_ptr = '0;
        int unsigned       fill = 0;
        bit                on_task [WORKERS];
        logic [ID_W-1:0]   cur_id [WORKERS];
        logic [UNITS_W-1:0] cur_units [WORKERS];
        logic [PROG_W-1:0] cur_prog [WORKERS];
        logic [MASK_W-1:0] offline = '0;
        t_out_item         step_events [$];
        t_out_item         expected_events [$];
        int                mismatches = 0;

        function void push_event(int w, t_event ev, logic [ID_W-1:0] id,
                                 logic [PROG_W-1:0] prog);
            t_out_item r;
            r = '0;
            r.worker        = 3'(w);
            r.event_res     = ev;
            r.event_task_id = id;
            r.progress      = prog;
            step_events.push_back(r);
        endfunction

        function void predict_events(t_in_item it);
            int                w;
            int                k;
            t_task_entry       head_entry;
            logic [PROG_W-1:0] next_prog;
            step_events.delete();
            if (it.action == ACT_ENQUEUE) begin
                if (fill >= QUEUE_DEPTH) begin
                    push_event(0, EV_FULL, it.task_id, '0);
                end else begin
                    pending_q[tail_ptr].id   = it.task_id;
                    pending_q[tail_ptr].work = it.work_units;
                    tail_ptr++;
                    fill++;
                    push_event(0, EV_ENQUEUED, it.task_id, '0);
                end
            end else begin
                for (w = 0; w < WORKERS; w++) begin
                    if (offline[w]) begin
                        if (on_task[w]) begin
                            push_event(w, EV_OFFLINE, cur_id[w], cur_prog[w]);
                        end else begin
                            push_event(w, EV_OFFLINE, '0, '0);
                        end
                    end else if (!on_task[w]) begin
                        if (fill != 0) begin
                            head_entry = pending_q[head_ptr];
                            head_ptr++;
                            fill--;
                            on_task[w]   = 1'b1;
                            cur_id[w]    = head_entry.id;
                            cur_units[w] = head_entry.work;
                            cur_prog[w]  = '0;
                            push_event(w, EV_DISPATCHED, head_entry.id, '0);
                        end else begin
                            push_event(w, EV_IDLE, '0, '0);
                        end
                    end else begin
                        next_prog   = cur_prog[w] + PROGRESS_STEP;
                        cur_prog[w] = next_prog;
                        if (next_prog >= {1'b0, cur_units[w]}) begin
                            on_task[w] = 1'b0;
                            push_event(w, EV_COMPLETED, cur_id[w], next_prog);
                        end else begin
                            push_event(w, EV_BUSY, cur_id[w], next_prog);
                        end
                    end
                end
            end
            for (k = 0; k < step_events.size(); k++) begin
                step_events[k].queue_count = 5'(fill);
                step_events[k].last        = (k == step_events.size() - 1);
                expected_events.push_back(step_events[k]);
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_event(t_out_item got);
            t_out_item want;
            if (expected_events.size() == 0) begin
                $error("Unexpected result: worker %0d, event %0d, task %0h",
                       got.worker, got.event_res, got.event_task_id);
                mismatches++;
                return;
            end
            want = expected_events.pop_front();
            compare_field("worker", 32'(want.worker), 32'(got.worker));
            compare_field("event_res", 32'(want.event_res), 32'(got.event_res));
            compare_field("event_task_id", 32'(want.event_task_id),
                          32'(got.event_task_id));
            compare_field("progress", 32'(want.progress), 32'(got.progress));
            compare_field("queue_count", 32'(want.queue_count), 32'(got.queue_count));
            compare_field("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_in_item          i_in_data;
    logic              o_out_valid;
    logic              i_out_stall;
    t_out_item         o_out_data;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [MASK_W-1:0] i_cfg_data;

    dispatch_board board;
    bit            no_send_gap;
    bit            no_out_stall;
    int            out_hold;
    int            idle_cycles;

    task_dispatch_sweep_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_in_item make_item(logic action, logic [ID_W-1:0] id,
                                           logic [UNITS_W-1:0] units);
        t_in_item it;
        it.action     = action;
        it.task_id    = id;
        it.work_units = units;
        return it;
    endfunction

    function automatic t_in_item random_item(int enq_pct);
        logic [UNITS_W-1:0] units;
        if ($urandom_range(0, 9) == 0) begin
            units = UNITS_W'($urandom_range(17, 40));
        end else begin
            units = UNITS_W'($urandom_range(1, 16));
        end
        return make_item(($urandom_range(0, 99) < enq_pct) ? ACT_ENQUEUE : ACT_SWEEP,
                         ID_W'($urandom), units);
    endfunction

    task automatic send_item(t_in_item it);
        int gap;
        gap = no_send_gap ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        board.predict_events(it);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (board.expected_events.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_mask(logic [MASK_W-1:0] mask);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mask;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        board.offline = mask;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int hold;
        i_out_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            hold = no_out_stall ? 0 : $urandom_range(0, 4);
            if (out_hold > 0) begin
                hold     = out_hold;
                out_hold = 0;
            end
            @(negedge i_clk);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
            board.check_event(o_out_data);
        end
    end

    initial begin
        idle_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
                (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Verification failed");
        $finish;
    end

    initial begin
        int                p;
        int                n;
        int                enq_pct;
        logic [MASK_W-1:0] mask;
        board        = new;
        no_send_gap  = 1'b0;
        no_out_stall = 1'b0;
        out_hold     = 0;
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_data    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Empty sweep, extreme fields, zero work units, then a full queue.
        send_item(make_item(ACT_SWEEP, 16'h0000, 16'h0000));
        send_item(make_item(ACT_ENQUEUE, 16'h0000, 16'd1));
        send_item(make_item(ACT_ENQUEUE, 16'hFFFF, 16'hFFFF));
        send_item(make_item(ACT_ENQUEUE, 16'h1234, 16'd0));
        send_item(make_item(ACT_ENQUEUE, 16'hA5A5, 16'd2));
        send_item(make_item(ACT_SWEEP, 16'hFFFF, 16'hFFFF));
        send_item(make_item(ACT_SWEEP, 16'h5A5A, 16'h0001));
        for (n = 0; n < QUEUE_DEPTH + 1; n++) begin
            send_item(make_item(ACT_ENQUEUE, ID_W'($urandom),
                                UNITS_W'($urandom_range(1, 8))));
        end
        send_item(make_item(ACT_SWEEP, 16'h0000, 16'h0000));

        for (p = 0; p < PHASES; p++) begin
            drain_results();
            mask = (p == 4) ? MASK_W'($urandom_range(0, 255)) : PHASE_MASKS[p];
            write_mask(mask);
            enq_pct      = (p % 2 == 0) ? 65 : 40;
            no_send_gap  = (p == 5);
            no_out_stall = (p == 5);
            for (n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 2 && n == PHASE_ITEMS / 2) begin
                    out_hold    = LONG_HOLD;
                    no_send_gap = 1'b1;
                    repeat (BURST_ITEMS) send_item(random_item(50));
                    no_send_gap = 1'b0;
                end
                if (p == 3 && n == PHASE_ITEMS / 2) begin
                    drain_results();
                end
                send_item(random_item(enq_pct));
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.expected_events.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
design/tds_pkg.sv
design/tds_fifo.sv
design/tds_workers.sv
design/task_dispatch_sweep_top.sv
sim/task_dispatch_sweep_top_tb.sv
